// ----- sv/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, constants and the hue sector code for the HSV to RGB
// conversion pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Field widths of the request and result items
  localparam int HUE_W   = 16;
  localparam int FIELD_W = 17;
  localparam int CH_W    = 8;

  // Hue fraction inside a sector, and one full sector in that scale
  localparam int FRAC_W = 16;
  localparam logic [FRAC_W:0] HUE_ONE = {1'b1, {FRAC_W{1'b0}}};

  // Default fraction bits of saturation, brightness and opacity
  localparam int FRAC_BITS_DEF = 16;

  // Largest channel value
  localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

  // Hue sector, the integer part of six times the hue
  localparam int SECT_W = 3;
  typedef enum logic [SECT_W-1:0] {
    SECT_0 = 3'd0,
    SECT_1 = 3'd1,
    SECT_2 = 3'd2,
    SECT_3 = 3'd3,
    SECT_4 = 3'd4,
    SECT_5 = 3'd5
  } sector_e;

endpackage

// ----- sv/hsv2rgb_if.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb interfaces
// Valid/ready channels for the HSV request and the RGBA result.
// ----------------------------------------------------------------------------
interface hsv2rgb_in_if;
  import hsv2rgb_pkg::*;

  logic               valid;
  logic               ready;
  logic [HUE_W-1:0]   hue;
  logic [FIELD_W-1:0] saturation;
  logic [FIELD_W-1:0] brightness;
  logic [FIELD_W-1:0] opacity;

  modport source (output valid, hue, saturation, brightness, opacity, input ready);
  modport sink   (input valid, hue, saturation, brightness, opacity, output ready);
endinterface

interface hsv2rgb_out_if;
  import hsv2rgb_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic [CH_W-1:0] alpha_out;

  modport source (output valid, red, green, blue, alpha_out, input ready);
  modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

// ----- sv/hsv_to_rgb_convert.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert
// Converts one HSV pixel with opacity into 8-bit RGBA.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i carries one request per pixel: 16-bit hue (fraction of a turn) and
//   17-bit saturation, brightness and opacity (1 << FRAC_BITS is 1.0; larger
//   values count as 1.0). pix_o returns red, green, blue and alpha_out.
//   A request is taken at a clock edge with valid and ready both high.
//   Each request passes through the clamp and sector, factors, brightness
//   products, and scale and route registers, in that order, to pix_o.
//   Throughput is one pixel per cycle while the receiver keeps ready high;
//   the four register stages each hold one pixel, and the two product
//   stages (17x16 and 17x17 at the default width) bound the clock.
//   Reset clears the stage valid bits only; the pipeline comes out empty.
//   When the receiver stalls, the result holds on pix_o, empty stages keep
//   filling behind it, and pix_i.ready drops only once all four stages hold
//   a pixel. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert
  import hsv2rgb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hsv2rgb_in_if.sink           pix_i,
  hsv2rgb_out_if.source        pix_o
);

  localparam int VW = FRAC_BITS + 1;

  // Stage 1 to 2
  logic              prep_vld, coef_rdy;
  sector_e           prep_sect;
  logic [FRAC_W-1:0] prep_frac;
  logic [VW-1:0]     prep_sat, prep_val, prep_alpha;
  logic              prep_gray;

  // Stage 2 to 3
  logic              coef_vld, mul_rdy;
  sector_e           coef_sect;
  logic [VW-1:0]     coef_val, coef_kp, coef_kq, coef_kt;
  logic [CH_W-1:0]   coef_vv, coef_av;
  logic              coef_gray;

  // Stage 3 to 4
  logic              mul_vld, mix_rdy;
  sector_e           mul_sect;
  logic [2*VW-1:0]   mul_pp, mul_pq, mul_pt;
  logic [CH_W-1:0]   mul_vv, mul_av;
  logic              mul_gray;

  hsv2rgb_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_i.valid),
    .ready_o (pix_i.ready),
    .hue_i   (pix_i.hue),
    .sat_i   (pix_i.saturation),
    .val_i   (pix_i.brightness),
    .alpha_i (pix_i.opacity),
    .valid_o (prep_vld),
    .ready_i (coef_rdy),
    .sect_o  (prep_sect),
    .frac_o  (prep_frac),
    .sat_o   (prep_sat),
    .val_o   (prep_val),
    .alpha_o (prep_alpha),
    .gray_o  (prep_gray)
  );

  hsv2rgb_coef #(.FRAC_BITS(FRAC_BITS)) u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_vld),
    .ready_o (coef_rdy),
    .sect_i  (prep_sect),
    .frac_i  (prep_frac),
    .sat_i   (prep_sat),
    .val_i   (prep_val),
    .alpha_i (prep_alpha),
    .gray_i  (prep_gray),
    .valid_o (coef_vld),
    .ready_i (mul_rdy),
    .sect_o  (coef_sect),
    .val_o   (coef_val),
    .kp_o    (coef_kp),
    .kq_o    (coef_kq),
    .kt_o    (coef_kt),
    .vv_o    (coef_vv),
    .av_o    (coef_av),
    .gray_o  (coef_gray)
  );

  hsv2rgb_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (coef_vld),
    .ready_o (mul_rdy),
    .sect_i  (coef_sect),
    .val_i   (coef_val),
    .kp_i    (coef_kp),
    .kq_i    (coef_kq),
    .kt_i    (coef_kt),
    .vv_i    (coef_vv),
    .av_i    (coef_av),
    .gray_i  (coef_gray),
    .valid_o (mul_vld),
    .ready_i (mix_rdy),
    .sect_o  (mul_sect),
    .pp_o    (mul_pp),
    .pq_o    (mul_pq),
    .pt_o    (mul_pt),
    .vv_o    (mul_vv),
    .av_o    (mul_av),
    .gray_o  (mul_gray)
  );

  hsv2rgb_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_vld),
    .ready_o (mix_rdy),
    .sect_i  (mul_sect),
    .pp_i    (mul_pp),
    .pq_i    (mul_pq),
    .pt_i    (mul_pt),
    .vv_i    (mul_vv),
    .av_i    (mul_av),
    .gray_i  (mul_gray),
    .valid_o (pix_o.valid),
    .ready_i (pix_o.ready),
    .red_o   (pix_o.red),
    .green_o (pix_o.green),
    .blue_o  (pix_o.blue),
    .alpha_o (pix_o.alpha_out)
  );

`ifndef NO_ASSERTIONS
  // Request side backs up only when every stage is full and the output stalls
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (prep_vld && coef_vld && mul_vld && pix_o.valid && !pix_o.ready))
    else $error("request stalled while the pipeline has room");

  // A stalled product stage keeps its pixel
  a_mul_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_vld && !mix_rdy) |=> mul_vld)
    else $error("product stage lost a pixel under stall");

  // A gray pixel leaves with equal color channels
  a_gray_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_vld && mix_rdy && mul_gray) |=>
      (pix_o.valid && pix_o.red == pix_o.green && pix_o.green == pix_o.blue))
    else $error("gray pixel with unequal channels");
`endif

endmodule

// ----- sv/hsv2rgb_prep.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_prep
// First stage: clamp the fractions to one, split six times the hue into
// sector and fraction, flag zero saturation.
// ----------------------------------------------------------------------------
module hsv2rgb_prep
  import hsv2rgb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int VW = FRAC_BITS + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [HUE_W-1:0]   hue_i,
  input  logic [FIELD_W-1:0] sat_i,
  input  logic [FIELD_W-1:0] val_i,
  input  logic [FIELD_W-1:0] alpha_i,
  output logic               valid_o,
  input  logic               ready_i,
  output sector_e            sect_o,
  output logic [FRAC_W-1:0]  frac_o,
  output logic [VW-1:0]      sat_o,
  output logic [VW-1:0]      val_o,
  output logic [VW-1:0]      alpha_o,
  output logic               gray_o
);

  localparam int CMPW = (VW > FIELD_W) ? VW : FIELD_W;
  localparam logic [CMPW-1:0] ONE_C = CMPW'(1) << FRAC_BITS;

  function automatic logic [VW-1:0] clamp_one(input logic [FIELD_W-1:0] x);
    logic [CMPW-1:0] ext;
    ext = CMPW'(x);
    if (ext > ONE_C) begin
      ext = ONE_C;
    end
    return VW'(ext);
  endfunction

  logic               vld_q;
  logic [HUE_W+2:0]   h6;
  logic [VW-1:0]      sat_c;
  sector_e            sect_q;
  logic [FRAC_W-1:0]  frac_q;
  logic [VW-1:0]      sat_q, val_q, alpha_q;
  logic               gray_q;

  // Six times the hue as 4x + 2x
  assign h6    = {1'b0, hue_i, 2'b00} + {2'b00, hue_i, 1'b0};
  assign sat_c = clamp_one(sat_i);

  // Advance when the stage is empty or the next one takes its item
  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sect_q  <= sector_e'(h6[HUE_W+2:HUE_W]);
      frac_q  <= h6[FRAC_W-1:0];
      sat_q   <= sat_c;
      val_q   <= clamp_one(val_i);
      alpha_q <= clamp_one(alpha_i);
      gray_q  <= (sat_c == '0);
    end
  end

  assign valid_o = vld_q;
  assign sect_o  = sect_q;
  assign frac_o  = frac_q;
  assign sat_o   = sat_q;
  assign val_o   = val_q;
  assign alpha_o = alpha_q;
  assign gray_o  = gray_q;

endmodule

// ----- sv/hsv2rgb_coef.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_coef
// Second stage: form the factors 1-s, 1-s*f and 1-s*(1-f), and scale
// brightness and opacity to eight bits.
// ----------------------------------------------------------------------------
module hsv2rgb_coef
  import hsv2rgb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int VW = FRAC_BITS + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  sector_e           sect_i,
  input  logic [FRAC_W-1:0] frac_i,
  input  logic [VW-1:0]     sat_i,
  input  logic [VW-1:0]     val_i,
  input  logic [VW-1:0]     alpha_i,
  input  logic              gray_i,
  output logic              valid_o,
  input  logic              ready_i,
  output sector_e           sect_o,
  output logic [VW-1:0]     val_o,
  output logic [VW-1:0]     kp_o,
  output logic [VW-1:0]     kq_o,
  output logic [VW-1:0]     kt_o,
  output logic [CH_W-1:0]   vv_o,
  output logic [CH_W-1:0]   av_o,
  output logic              gray_o
);

  localparam logic [VW-1:0] ONE_V = {1'b1, {FRAC_BITS{1'b0}}};

  // x * 255 >> FRAC_BITS, saturated to eight bits
  function automatic logic [CH_W-1:0] scale8(input logic [VW-1:0] x);
    logic [VW+CH_W-1:0] m;
    m = {x, {CH_W{1'b0}}} - {{CH_W{1'b0}}, x};
    return m[FRAC_BITS+CH_W] ? CH_MAX : m[FRAC_BITS+CH_W-1:FRAC_BITS];
  endfunction

  logic [FRAC_W:0]      frac_c;
  logic [VW+FRAC_W-1:0] s_f;
  logic [VW+FRAC_W:0]   s_g;
  logic [VW-1:0]        sf, sg;

  logic                 vld_q;
  sector_e              sect_q;
  logic [VW-1:0]        val_q, kp_q, kq_q, kt_q;
  logic [CH_W-1:0]      vv_q, av_q;
  logic                 gray_q;

  // s*f and s*(1-f), both kept at the saturation scale
  assign frac_c = HUE_ONE - {1'b0, frac_i};
  assign s_f    = (VW+FRAC_W)'(sat_i) * (VW+FRAC_W)'(frac_i);
  assign s_g    = (VW+FRAC_W+1)'(sat_i) * (VW+FRAC_W+1)'(frac_c);
  assign sf     = s_f[VW+FRAC_W-1:FRAC_W];
  assign sg     = s_g[VW+FRAC_W-1:FRAC_W];

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sect_q <= sect_i;
      val_q  <= val_i;
      kp_q   <= ONE_V - sat_i;
      kq_q   <= ONE_V - sf;
      kt_q   <= ONE_V - sg;
      vv_q   <= scale8(val_i);
      av_q   <= scale8(alpha_i);
      gray_q <= gray_i;
    end
  end

  assign valid_o = vld_q;
  assign sect_o  = sect_q;
  assign val_o   = val_q;
  assign kp_o    = kp_q;
  assign kq_o    = kq_q;
  assign kt_o    = kt_q;
  assign vv_o    = vv_q;
  assign av_o    = av_q;
  assign gray_o  = gray_q;

endmodule

// ----- sv/hsv2rgb_mul.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_mul
// Third stage: multiply brightness by each of the three factors.
// ----------------------------------------------------------------------------
module hsv2rgb_mul
  import hsv2rgb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int VW = FRAC_BITS + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  sector_e         sect_i,
  input  logic [VW-1:0]   val_i,
  input  logic [VW-1:0]   kp_i,
  input  logic [VW-1:0]   kq_i,
  input  logic [VW-1:0]   kt_i,
  input  logic [CH_W-1:0] vv_i,
  input  logic [CH_W-1:0] av_i,
  input  logic            gray_i,
  output logic            valid_o,
  input  logic            ready_i,
  output sector_e         sect_o,
  output logic [2*VW-1:0] pp_o,
  output logic [2*VW-1:0] pq_o,
  output logic [2*VW-1:0] pt_o,
  output logic [CH_W-1:0] vv_o,
  output logic [CH_W-1:0] av_o,
  output logic            gray_o
);

  localparam int PW = 2 * VW;

  logic            vld_q;
  sector_e         sect_q;
  logic [PW-1:0]   pp_q, pq_q, pt_q;
  logic [CH_W-1:0] vv_q, av_q;
  logic            gray_q;

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  // Three parallel brightness products
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sect_q <= sect_i;
      pp_q   <= PW'(val_i) * PW'(kp_i);
      pq_q   <= PW'(val_i) * PW'(kq_i);
      pt_q   <= PW'(val_i) * PW'(kt_i);
      vv_q   <= vv_i;
      av_q   <= av_i;
      gray_q <= gray_i;
    end
  end

  assign valid_o = vld_q;
  assign sect_o  = sect_q;
  assign pp_o    = pp_q;
  assign pq_o    = pq_q;
  assign pt_o    = pt_q;
  assign vv_o    = vv_q;
  assign av_o    = av_q;
  assign gray_o  = gray_q;

endmodule

// ----- sv/hsv2rgb_mix.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_mix
// Last stage: scale the products to eight bits and route them to the
// channels by hue sector; gray pixels take the brightness on all three.
// ----------------------------------------------------------------------------
module hsv2rgb_mix
  import hsv2rgb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int VW = FRAC_BITS + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  sector_e         sect_i,
  input  logic [2*VW-1:0] pp_i,
  input  logic [2*VW-1:0] pq_i,
  input  logic [2*VW-1:0] pt_i,
  input  logic [CH_W-1:0] vv_i,
  input  logic [CH_W-1:0] av_i,
  input  logic            gray_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [CH_W-1:0] red_o,
  output logic [CH_W-1:0] green_o,
  output logic [CH_W-1:0] blue_o,
  output logic [CH_W-1:0] alpha_o
);

  localparam int PW = 2 * VW;
  localparam int SH = 2 * FRAC_BITS;

  // prod * 255 >> 2*FRAC_BITS, saturated to eight bits
  function automatic logic [CH_W-1:0] scale8(input logic [PW-1:0] x);
    logic [PW+CH_W-1:0] m;
    m = {x, {CH_W{1'b0}}} - {{CH_W{1'b0}}, x};
    return (|m[PW+CH_W-1:SH+CH_W]) ? CH_MAX : m[SH+CH_W-1:SH];
  endfunction

  logic [CH_W-1:0] p8, q8, t8;
  logic [CH_W-1:0] r_d, g_d, b_d;

  logic            vld_q;
  logic [CH_W-1:0] red_q, green_q, blue_q, alpha_q;

  assign p8 = scale8(pp_i);
  assign q8 = scale8(pq_i);
  assign t8 = scale8(pt_i);

  // Route by sector
  always_comb begin
    case (sect_i)
      SECT_0: begin
        r_d = vv_i; g_d = t8;   b_d = p8;
      end
      SECT_1: begin
        r_d = q8;   g_d = vv_i; b_d = p8;
      end
      SECT_2: begin
        r_d = p8;   g_d = vv_i; b_d = t8;
      end
      SECT_3: begin
        r_d = p8;   g_d = q8;   b_d = vv_i;
      end
      SECT_4: begin
        r_d = t8;   g_d = p8;   b_d = vv_i;
      end
      default: begin
        r_d = vv_i; g_d = p8;   b_d = q8;
      end
    endcase
    if (gray_i) begin
      r_d = vv_i;
      g_d = vv_i;
      b_d = vv_i;
    end
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      red_q   <= r_d;
      green_q <= g_d;
      blue_q  <= b_d;
      alpha_q <= av_i;
    end
  end

  assign valid_o = vld_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;
  assign alpha_o = alpha_q;

endmodule
